// ===== src/lccf_pkg.sv =====
// Shared widths, mode codes and inter-module types for the collision count filter.
`timescale 1ns / 1ps
`default_nettype none
package lccf_pkg;

	localparam int ID_W   = 12;
	localparam int CNT_W  = 7;
	localparam int MODE_W = 2;

	localparam logic [MODE_W-1:0] MODE_CAND      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_END_QUERY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_END_JOIN  = 2'd2;

	typedef struct packed {
		logic            push;
		logic [ID_W-1:0] id;
	} lccf_push_t;

	typedef struct packed {
		logic [1:0] level;
		logic       pop;
	} lccf_qstat_t;

endpackage
`default_nettype wire

// ===== src/lccf_if.sv =====
// Channel interfaces: candidate input and match output.
`timescale 1ns / 1ps
`default_nettype none
interface lccf_cand_if;
	logic                        valid;
	logic                        ready;
	logic [lccf_pkg::MODE_W-1:0] mode;
	logic [lccf_pkg::ID_W-1:0]   candidate_id;

	modport source (output valid, output mode, output candidate_id, input ready);
	modport sink (input valid, input mode, input candidate_id, output ready);
endinterface

interface lccf_match_if;
	logic                      valid;
	logic                      ready;
	logic [lccf_pkg::ID_W-1:0] match_id;

	modport source (output valid, output match_id, input ready);
	modport sink (input valid, input match_id, output ready);
endinterface
`default_nettype wire

// ===== src/lccf_outq.sv =====
// Two-entry output queue that holds matched ids until the sink takes them.
`timescale 1ns / 1ps
`default_nettype none
module lccf_outq (
	input wire                          clk,
	input wire                          arst_n,
	input wire lccf_pkg::lccf_push_t    push,
	output lccf_pkg::lccf_qstat_t       stat,
	lccf_match_if.source                match
);

	logic [lccf_pkg::ID_W-1:0] entry_q [2];
	logic                      head_q;
	logic                      tail_q;
	logic [1:0]                level_q;
	logic                      pop;

	assign pop            = match.valid && match.ready;
	assign match.valid    = (level_q != 2'd0);
	assign match.match_id = entry_q[head_q];
	assign stat.level     = level_q;
	assign stat.pop       = pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= 1'b0;
			tail_q  <= 1'b0;
			level_q <= 2'd0;
		end else begin
			if (push.push) begin
				tail_q <= ~tail_q;
			end
			if (pop) begin
				head_q <= ~head_q;
			end
			level_q <= level_q + 2'(push.push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.push) begin
			entry_q[tail_q] <= push.id;
		end
	end

endmodule
`default_nettype wire

// ===== src/lsh_collision_count_filter.sv =====
// Top level: per-id collision counts and reported flags in two memories, threshold match.
//
//  channel   dir  handshake          payload
//  cand      in   valid/ready        mode[1:0], candidate_id[11:0]
//  match     out  valid/ready        match_id[11:0]
//  cfg       in   cfg_we (no wait)   cfg_wdata[6:0] -> threshold_k
//
// Candidate items: one per cycle while cand.ready holds; read in the accept cycle,
//   read-modify-write in the next cycle, forwarding the prior write; match valid once queued.
// End-of-query / end-of-join items: a sweep over min(MAX_IDS, 4096) entries zeroes the count
//   or reported memory, one entry a cycle; cand.ready is low meanwhile.
// After reset the same sweep clears both memories before the first item is taken.
// cand.ready also drops when the two-entry output queue could not absorb a result.
`timescale 1ns / 1ps
`default_nettype none
module lsh_collision_count_filter #(
	parameter int MAX_IDS    = 4096,
	parameter int MAX_TABLES = 64
) (
	input wire                            clk,
	input wire                            arst_n,
	lccf_cand_if.sink                     cand,
	lccf_match_if.source                  match,
	input wire                            cfg_we,
	input wire [lccf_pkg::CNT_W-1:0]      cfg_wdata
);

	localparam int ID_SPAN = 1 << lccf_pkg::ID_W;
	localparam int DEPTH   = (MAX_IDS < ID_SPAN) ? MAX_IDS : ID_SPAN;
	localparam int AW      = $clog2(DEPTH);
	localparam bit ALL_IN  = (MAX_IDS >= ID_SPAN);
	localparam logic [lccf_pkg::ID_W-1:0] ID_LIM =
		ALL_IN ? {lccf_pkg::ID_W{1'b1}} : lccf_pkg::ID_W'(MAX_IDS);
	localparam logic [lccf_pkg::CNT_W-1:0] CNT_MAX = lccf_pkg::CNT_W'(MAX_TABLES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} lccf_state_t;

	lccf_state_t st_q;
	logic [AW-1:0]              sweep_addr_q;
	logic                       clr_cnt_q;
	logic                       clr_rep_q;
	logic [lccf_pkg::CNT_W-1:0] thr_q;

	logic [lccf_pkg::CNT_W-1:0] cnt_mem [DEPTH];
	logic                       rep_mem [DEPTH];
	logic [lccf_pkg::CNT_W-1:0] cnt_rd_q;
	logic                       rep_rd_q;

	logic                       valid_s1;
	logic [AW-1:0]              addr_s1;

	logic                       fwd_valid_q;
	logic [AW-1:0]              fwd_addr_q;
	logic [lccf_pkg::CNT_W-1:0] fwd_cnt_q;
	logic                       fwd_rep_q;

	logic                       cand_fire;
	logic                       in_range;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic                       fwd_hit;
	logic [lccf_pkg::CNT_W-1:0] cnt_cur;
	logic                       rep_cur;
	logic                       sat;
	logic [lccf_pkg::CNT_W-1:0] cnt_nxt;
	logic                       hit;
	logic                       rep_nxt;
	logic                       sweeping;
	logic                       cnt_we;
	logic                       rep_we;
	logic [AW-1:0]              wr_addr;
	logic [lccf_pkg::CNT_W-1:0] cnt_wdata;
	logic                       rep_wdata;
	logic [2:0]                 occ;
	lccf_pkg::lccf_push_t       qpush;
	lccf_pkg::lccf_qstat_t      qstat;

	// an s1 result may land while the queue drains; keep room for it
	assign occ        = 3'(qstat.level) + 3'(valid_s1);
	assign cand.ready = (st_q == ST_RUN) && (occ <= 3'd1 + 3'(qstat.pop));
	assign cand_fire  = cand.valid && cand.ready;

	assign in_range = ALL_IN || (cand.candidate_id < ID_LIM);
	assign rd_en    = cand_fire && (cand.mode == lccf_pkg::MODE_CAND) && in_range;
	assign rd_addr  = cand.candidate_id[AW-1:0];

	// the write of the previous item is not yet visible in the read data
	assign fwd_hit = fwd_valid_q && (fwd_addr_q == addr_s1);
	assign cnt_cur = fwd_hit ? fwd_cnt_q : cnt_rd_q;
	assign rep_cur = fwd_hit ? fwd_rep_q : rep_rd_q;
	assign sat     = (cnt_cur >= CNT_MAX);
	assign cnt_nxt = sat ? cnt_cur : cnt_cur + lccf_pkg::CNT_W'(1);
	assign hit     = valid_s1 && !sat && (cnt_nxt == thr_q) && !rep_cur;
	assign rep_nxt = rep_cur | hit;

	assign sweeping  = (st_q == ST_CLEAR);
	assign cnt_we    = valid_s1 || (sweeping && clr_cnt_q);
	assign rep_we    = valid_s1 || (sweeping && clr_rep_q);
	assign wr_addr   = sweeping ? sweep_addr_q : addr_s1;
	assign cnt_wdata = sweeping ? '0 : cnt_nxt;
	assign rep_wdata = sweeping ? 1'b0 : rep_nxt;

	assign qpush.push = hit;
	assign qpush.id   = lccf_pkg::ID_W'(addr_s1);

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[wr_addr] <= cnt_wdata;
		end
		if (rep_we) begin
			rep_mem[wr_addr] <= rep_wdata;
		end
		if (rd_en) begin
			cnt_rd_q <= cnt_mem[rd_addr];
			rep_rd_q <= rep_mem[rd_addr];
			addr_s1  <= rd_addr;
		end
		if (valid_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_cnt_q  <= cnt_nxt;
			fwd_rep_q  <= rep_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_CLEAR;
			sweep_addr_q <= '0;
			clr_cnt_q    <= 1'b1;
			clr_rep_q    <= 1'b1;
			thr_q        <= lccf_pkg::CNT_W'(1);
			valid_s1     <= 1'b0;
			fwd_valid_q  <= 1'b0;
		end else begin
			valid_s1    <= rd_en;
			fwd_valid_q <= valid_s1;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			case (st_q)
				ST_CLEAR: begin
					sweep_addr_q <= sweep_addr_q + AW'(1);
					if (sweep_addr_q == LAST_ADDR) begin
						st_q      <= ST_RUN;
						clr_cnt_q <= 1'b0;
						clr_rep_q <= 1'b0;
					end
				end
				ST_RUN: begin
					sweep_addr_q <= '0;
					if (cand_fire && (cand.mode == lccf_pkg::MODE_END_QUERY)) begin
						st_q      <= ST_CLEAR;
						clr_cnt_q <= 1'b1;
					end else if (cand_fire && (cand.mode == lccf_pkg::MODE_END_JOIN)) begin
						st_q      <= ST_CLEAR;
						clr_rep_q <= 1'b1;
					end
				end
				default: begin
					st_q <= ST_CLEAR;
				end
			endcase
		end
	end

	lccf_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (qpush),
		.stat   (qstat),
		.match  (match)
	);

`ifndef SYNTH
	a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLEAR) |-> !cand.ready)
		else $error("item taken during memory sweep");

	a_s1_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ($past(st_q) == ST_RUN))
		else $error("read-modify-write without a preceding accept");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		qpush.push |-> !((qstat.level == 2'd2) && !qstat.pop))
		else $error("match pushed into a full output queue");

	a_sweep_from_zero: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_CLEAR) && ($past(st_q) == ST_RUN)) |-> (sweep_addr_q == '0))
		else $error("clear sweep did not start at entry zero");
`endif

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking bench for the collision count filter: queued stimulus, scoreboard, threshold sweeps.
`timescale 1ns / 1ps
module testbench;

	localparam int IDS         = 4096;
	localparam int TABLES      = 64;
	localparam int PHASE_ITEMS = 60;
	localparam int CYCLE_LIMIT = 4_000_000;

	// mode 3 has no meaning; the block must drop it
	localparam logic [lccf_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [lccf_pkg::MODE_W-1:0] mode;
		logic [lccf_pkg::ID_W-1:0]   id;
	} cand_item_t;

	typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PATTERN} rdy_style_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [lccf_pkg::CNT_W-1:0] cfg_wdata;

	lccf_cand_if  cand_ch ();
	lccf_match_if match_ch ();

	lsh_collision_count_filter #(
		.MAX_IDS    (IDS),
		.MAX_TABLES (TABLES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cand      (cand_ch),
		.match     (match_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shadow state of the filter
	bit [lccf_pkg::CNT_W-1:0]   hit_count [IDS];
	bit                         reported_flag [IDS];
	logic [lccf_pkg::CNT_W-1:0] thr_model = 7'd1;

	cand_item_t                  cand_backlog[$];
	logic [lccf_pkg::ID_W-1:0]   due_match_ids[$];
	logic [lccf_pkg::ID_W-1:0]   join_pool[$];

	int unsigned pushed_all    = 0;
	int unsigned pushed_real   = 0;
	int unsigned accepted_all  = 0;
	int unsigned matched_count = 0;
	int unsigned mism_count    = 0;
	int unsigned settings_used = 1;
	int unsigned cycle_count   = 0;
	int unsigned phase_start   = 0;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cand_ch.valid = 1'b0;
		cand_ch.mode = lccf_pkg::MODE_CAND;
		cand_ch.candidate_id = '0;
		match_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("lsh_collision_count_filter: mismatch");
			$finish;
		end
	end

	task automatic track_collision(input logic [lccf_pkg::MODE_W-1:0] md,
			input logic [lccf_pkg::ID_W-1:0] id);
		int unsigned c;
		case (md)
			lccf_pkg::MODE_END_QUERY: begin
				foreach (hit_count[i]) hit_count[i] = '0;
			end
			lccf_pkg::MODE_END_JOIN: begin
				foreach (reported_flag[i]) reported_flag[i] = 1'b0;
			end
			lccf_pkg::MODE_CAND: begin
				c = hit_count[id];
				// saturated counts stay put and never trigger a report
				if (id < IDS && c < TABLES) begin
					c++;
					hit_count[id] = c[lccf_pkg::CNT_W-1:0];
					if (c == thr_model && !reported_flag[id]) begin
						reported_flag[id] = 1'b1;
						due_match_ids.insert(due_match_ids.size(), id);
					end
				end
			end
			default: ;
		endcase
	endtask

	// sender: bursts of random length separated by random gaps
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;
	cand_item_t  next_item;

	always @(posedge clk) begin
		if (!arst_n) begin
			cand_ch.valid <= 1'b0;
		end else begin
			if (cand_ch.valid && cand_ch.ready) begin
				track_collision(cand_ch.mode, cand_ch.candidate_id);
				accepted_all++;
			end
			if (!cand_ch.valid || cand_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					cand_ch.valid <= 1'b0;
				end else if (cand_backlog.size() > 0) begin
					next_item = cand_backlog.pop_front();
					cand_ch.valid <= 1'b1;
					cand_ch.mode <= next_item.mode;
					cand_ch.candidate_id <= next_item.id;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					cand_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall style is redrawn after each run of random length
	rdy_style_t  rdy_style = RDY_ALWAYS;
	int unsigned rdy_left  = 0;
	int unsigned rdy_phase = 0;
	logic [7:0]  rdy_pattern = 8'hFF;

	always @(posedge clk) begin
		if (!arst_n) begin
			match_ch.ready <= 1'b0;
		end else begin
			if (rdy_left == 0) begin
				rdy_style = rdy_style_t'($urandom_range(0, 3));
				rdy_left = $urandom_range(20, 200);
				rdy_pattern = $urandom_range(1, 255);
			end else begin
				rdy_left--;
			end
			rdy_phase++;
			case (rdy_style)
				RDY_ALWAYS: match_ch.ready <= 1'b1;
				RDY_COIN:   match_ch.ready <= $urandom_range(0, 1);
				RDY_SPARSE: match_ch.ready <= ($urandom_range(0, 3) == 0);
				default:    match_ch.ready <= rdy_pattern[rdy_phase % 8];
			endcase
		end
	end

	logic [lccf_pkg::ID_W-1:0] want_id;

	always @(posedge clk) begin
		if (arst_n && match_ch.valid && match_ch.ready) begin
			if (due_match_ids.size() == 0) begin
				$error("match_id: expected none, got %0d", match_ch.match_id);
				mism_count++;
			end else begin
				want_id = due_match_ids.pop_front();
				matched_count++;
				if (match_ch.match_id !== want_id) begin
					$error("match_id: expected %0d, got %0d", want_id, match_ch.match_id);
					mism_count++;
				end
			end
		end
	end

	task automatic push_item(input logic [lccf_pkg::MODE_W-1:0] md,
			input logic [lccf_pkg::ID_W-1:0] id);
		cand_item_t it;
		it.mode = md;
		it.id = id;
		cand_backlog.insert(cand_backlog.size(), it);
		pushed_all++;
		if (md != MODE_UNUSED)
			pushed_real++;
	endtask

	function automatic logic [lccf_pkg::ID_W-1:0] any_id();
		return $urandom_range(0, IDS - 1);
	endfunction

	// everything sent has been taken, nothing outstanding, and any clear sweep is over
	task automatic wait_idle();
		do @(posedge clk);
		while (cand_backlog.size() != 0 || accepted_all != pushed_all || due_match_ids.size() != 0);
		repeat (8) @(posedge clk);
		while (!cand_ch.ready) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [lccf_pkg::CNT_W-1:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		thr_model = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// one query: each pool id hit around the threshold, plus noise, shuffled
	task automatic add_query(input int thr);
		cand_item_t seq[$];
		cand_item_t it;
		int hits;
		int j;
		int k;
		foreach (join_pool[p]) begin
			if (thr >= 1 && thr <= TABLES)
				hits = thr - 2 + $urandom_range(0, 4);
			else
				hits = $urandom_range(1, TABLES + 4);
			if (hits < 1)
				hits = 1;
			it = '{lccf_pkg::MODE_CAND, join_pool[p]};
			repeat (hits) seq.insert(seq.size(), it);
		end
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 1))
				it = '{MODE_UNUSED, any_id()};
			else
				it = '{lccf_pkg::MODE_CAND, any_id()};
			seq.insert(seq.size(), it);
		end
		for (j = seq.size() - 1; j > 0; j--) begin
			k = $urandom_range(0, j);
			it = seq[j];
			seq[j] = seq[k];
			seq[k] = it;
		end
		// join ending in mid-query: counts survive, reports may repeat
		if ($urandom_range(0, 5) == 0) begin
			it = '{lccf_pkg::MODE_END_JOIN, any_id()};
			seq.insert($urandom_range(0, seq.size()), it);
		end
		foreach (seq[n]) push_item(seq[n].mode, seq[n].id);
		push_item(lccf_pkg::MODE_END_QUERY, any_id());
	endtask

	task automatic add_join(input int thr);
		int psize;
		if (thr >= 32 || thr == 0)
			psize = $urandom_range(1, 2);
		else if (thr >= 8)
			psize = $urandom_range(1, 3);
		else
			psize = $urandom_range(2, 8);
		join_pool.delete();
		repeat (psize) join_pool.insert(join_pool.size(), any_id());
		repeat ($urandom_range(1, 3)) begin
			// stop adding queries once the phase has its share of items
			if (pushed_real >= phase_start + PHASE_ITEMS)
				break;
			// keep most ids from the last query so the reported set is exercised
			if ($urandom_range(0, 1))
				join_pool[$urandom_range(0, psize - 1)] = any_id();
			add_query(thr);
		end
		push_item(lccf_pkg::MODE_END_JOIN, any_id());
	endtask

	int thr_plan[$];

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed, at the reset threshold of one
		push_item(lccf_pkg::MODE_CAND, 12'd0);
		push_item(lccf_pkg::MODE_CAND, 12'hFFF);
		push_item(lccf_pkg::MODE_CAND, 12'd0);
		push_item(MODE_UNUSED, 12'hFFF);
		push_item(lccf_pkg::MODE_END_QUERY, 12'hABC);
		push_item(lccf_pkg::MODE_CAND, 12'd0);
		push_item(lccf_pkg::MODE_CAND, 12'h555);
		push_item(lccf_pkg::MODE_END_JOIN, 12'hFFF);
		push_item(lccf_pkg::MODE_CAND, 12'd0);
		push_item(lccf_pkg::MODE_END_QUERY, 12'd0);
		push_item(lccf_pkg::MODE_CAND, 12'd0);
		push_item(lccf_pkg::MODE_CAND, 12'hAAA);
		push_item(lccf_pkg::MODE_CAND, 12'hAAA);
		push_item(lccf_pkg::MODE_END_JOIN, 12'd0);
		push_item(lccf_pkg::MODE_END_QUERY, 12'hFFF);

		thr_plan = '{64, 2, 0, 127, 65, 0, 1, 3, 0};
		thr_plan[5] = $urandom_range(4, 63);
		thr_plan[8] = $urandom_range(1, 64);

		foreach (thr_plan[p]) begin
			write_threshold(thr_plan[p][lccf_pkg::CNT_W-1:0]);
			phase_start = pushed_real;
			while (pushed_real < phase_start + PHASE_ITEMS)
				add_join(thr_plan[p]);
		end

		wait_idle();
		repeat (16) @(posedge clk);

		$display("covered %0d items (%0d ignored), %0d matches, %0d threshold settings",
			accepted_all, pushed_all - pushed_real, matched_count, settings_used);
		if (mism_count == 0 && due_match_ids.size() == 0)
			$display("lsh_collision_count_filter: match");
		else
			$display("lsh_collision_count_filter: mismatch");
		$finish;
	end

endmodule
